### sv/rtp_h264_fua_depacketizer_top_defines.svh
// Assertion macros for the RTP H.264 FU-A depacketizer.
// Used by the top level; needs signals clk and rst in scope.
`ifndef RTP_H264_FUA_DEPACKETIZER_TOP_DEFINES_SVH
`define RTP_H264_FUA_DEPACKETIZER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define RTPFUA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define RTPFUA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rtpfua_pkg.sv
// Shared types and constants for the RTP H.264 FU-A depacketizer.
// No dependencies.
package rtpfua_pkg;

  localparam int unsigned NumOut = 3;

  localparam logic [6:0] HdrBytes  = 7'd12;
  localparam logic [6:0] PosMax    = 7'd127;
  localparam logic [3:0] CsrcMask  = 4'hf;
  localparam logic [4:0] TypeMask  = 5'h1f;
  localparam logic [4:0] TypeStapA = 5'd24;
  localparam logic [4:0] TypeStapB = 5'd25;
  localparam logic [4:0] TypeFuA   = 5'd28;
  localparam logic [4:0] TypeFuB   = 5'd29;
  localparam logic [7:0] FnriMask  = 8'he0;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_COMMIT  = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CLS_IGNORED  = 3'd0,
    CLS_SINGLE   = 3'd1,
    CLS_FU_WAIT  = 3'd2,
    CLS_FU_START = 3'd3,
    CLS_FU_MID   = 3'd4,
    CLS_FU_END   = 3'd5
  } pclass_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eod;
  } in_item_t;

  // Up to three results from one datagram byte, entry 0 first
  typedef struct packed {
    logic [1:0]                count;
    kind_t [NumOut-1:0]        kind;
    logic  [NumOut-1:0][7:0]   value;
  } burst_t;

endpackage

### sv/rtp_h264_fua_depacketizer_top.sv
// Top level of the RTP H.264 depacketizer (single NAL unit and FU-A).
// Depends on rtpfua_pkg, rtpfua_in_buf, rtpfua_decode, rtpfua_out_seq and the defines header.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    in_byte, end_of_datagram
//   out      source     out_valid/out_ready  out_kind, out_value, last_of_run
//
// One datagram byte is decoded per cycle while the result register can load; a byte with
// a single result sustains one per cycle while out_ready is high. A byte with n results
// (up to 3) holds the decoder at the result register until its last result is taken.
// Reset clears the datagram position, class, open-NAL flag and both buffers.
// in_ready is a register (two-entry input buffer), so it does not follow out_ready combinationally.
`include "rtp_h264_fua_depacketizer_top_defines.svh"

module rtp_h264_fua_depacketizer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_datagram,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_value,
  output logic       last_of_run
);

  rtpfua_pkg::in_item_t in_item;
  rtpfua_pkg::in_item_t head_item;
  rtpfua_pkg::burst_t   burst;
  logic                 head_valid;
  logic                 can_load;
  logic                 take;

  assign in_item.data = in_byte;
  assign in_item.eod  = end_of_datagram;
  assign take         = head_valid && can_load;

  rtpfua_in_buf u_in_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (in_item),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (take)
  );

  rtpfua_decode u_decode (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .item  (head_item),
    .burst (burst)
  );

  rtpfua_out_seq u_out_seq (
    .clk         (clk),
    .rst         (rst),
    .load        (take),
    .burst       (burst),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_value   (out_value),
    .last_of_run (last_of_run)
  );

  `RTPFUA_ASSERT_IMPL(a_discard_not_last, out_valid && out_kind == rtpfua_pkg::KIND_DISCARD, !last_of_run, "discard ended a run")
  `RTPFUA_ASSERT_IMPL(a_commit_is_last, out_valid && out_kind == rtpfua_pkg::KIND_COMMIT, last_of_run, "commit not last in run")
  `RTPFUA_ASSERT_IMPL(a_marker_zero, out_valid && out_kind != rtpfua_pkg::KIND_DATA, out_value == 8'd0, "marker carries data")
  `RTPFUA_ASSERT_NEXT(a_run_continues, out_valid && !last_of_run && out_ready, out_valid, "run broken mid-way")

endmodule

### sv/rtpfua_in_buf.sv
// Two-entry input buffer with a registered ready.
// Depends on rtpfua_pkg.
module rtpfua_in_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  rtpfua_pkg::in_item_t push_item,
  output logic                 head_valid,
  output rtpfua_pkg::in_item_t head_item,
  input  logic                 pop
);

  logic [1:0]           count;
  logic [1:0]           count_next;
  rtpfua_pkg::in_item_t slot0;
  rtpfua_pkg::in_item_t slot1;
  logic                 push;

  assign push_ready = (count != 2'd2);
  assign push       = push_valid && push_ready;
  assign head_valid = (count != 2'd0);
  assign head_item  = slot0;

  always_comb begin
    count_next = count;
    case (count)
      2'd0: if (push) count_next = 2'd1;
      2'd1: begin
        if (push && !pop) count_next = 2'd2;
        else if (!push && pop) count_next = 2'd0;
      end
      2'd2: if (pop) count_next = 2'd1;
      default: count_next = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((count == 2'd0 && push) || (count == 2'd1 && pop && push)) begin
      slot0 <= push_item;
    end else if (count == 2'd2 && pop) begin
      slot0 <= slot1;
    end
    if (count == 2'd1 && push && !pop) begin
      slot1 <= push_item;
    end
  end

endmodule

### sv/rtpfua_decode.sv
// Per-byte RTP/FU-A decoder: datagram state and the result list of one byte.
// Depends on rtpfua_pkg.
module rtpfua_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  rtpfua_pkg::in_item_t item,
  output rtpfua_pkg::burst_t   burst
);

  logic [6:0]          byte_position;
  logic [6:0]          byte_position_next;
  logic [3:0]          contributor_count;
  logic [3:0]          contributor_count_next;
  logic [7:0]          saved_indicator;
  logic [7:0]          saved_indicator_next;
  rtpfua_pkg::pclass_t packet_class;
  rtpfua_pkg::pclass_t packet_class_next;
  logic                nal_open;
  logic                nal_open_next;

  logic [6:0] offset;
  logic [4:0] nal_type;
  logic       has_disc;
  logic       has_data;
  logic       has_commit;
  logic [7:0] data_val;
  logic [7:0] b;
  logic       eod;

  assign b   = item.data;
  assign eod = item.eod;

  always_comb begin
    contributor_count_next = contributor_count;
    saved_indicator_next   = saved_indicator;
    packet_class_next      = packet_class;
    nal_open_next          = nal_open;
    byte_position_next     = byte_position;
    has_disc               = 1'b0;
    has_data               = 1'b0;
    has_commit             = 1'b0;
    data_val               = b;
    nal_type               = b[4:0] & rtpfua_pkg::TypeMask;

    if (byte_position == 7'd0) begin
      contributor_count_next = b[3:0] & rtpfua_pkg::CsrcMask;
    end
    offset = rtpfua_pkg::HdrBytes + {1'b0, contributor_count_next, 2'b00};

    if (byte_position < offset) begin
      // header bytes: nothing
    end else if (byte_position == offset) begin
      if (nal_type == rtpfua_pkg::TypeStapA || nal_type == rtpfua_pkg::TypeStapB ||
          nal_type == rtpfua_pkg::TypeFuB) begin
        packet_class_next = rtpfua_pkg::CLS_IGNORED;
      end else if (nal_type == rtpfua_pkg::TypeFuA) begin
        saved_indicator_next = b;
        packet_class_next    = rtpfua_pkg::CLS_FU_WAIT;
      end else begin
        has_disc          = nal_open;
        has_data          = 1'b1;
        nal_open_next     = 1'b1;
        packet_class_next = rtpfua_pkg::CLS_SINGLE;
        if (eod) begin
          has_commit    = 1'b1;
          nal_open_next = 1'b0;
        end
      end
    end else if (byte_position == offset + 7'd1 &&
                 packet_class == rtpfua_pkg::CLS_FU_WAIT) begin
      if (b[7]) begin
        // start wins over end; rebuild the NAL header
        has_disc          = nal_open;
        has_data          = 1'b1;
        data_val          = (saved_indicator & rtpfua_pkg::FnriMask) | {3'b000, nal_type};
        nal_open_next     = 1'b1;
        packet_class_next = rtpfua_pkg::CLS_FU_START;
      end else if (nal_open) begin
        packet_class_next = b[6] ? rtpfua_pkg::CLS_FU_END : rtpfua_pkg::CLS_FU_MID;
        if (b[6] && eod) begin
          has_commit    = 1'b1;
          nal_open_next = 1'b0;
        end
      end else begin
        packet_class_next = rtpfua_pkg::CLS_IGNORED;
      end
    end else begin
      case (packet_class)
        rtpfua_pkg::CLS_SINGLE, rtpfua_pkg::CLS_FU_END: begin
          has_data = 1'b1;
          if (eod) begin
            has_commit    = 1'b1;
            nal_open_next = 1'b0;
          end
        end
        rtpfua_pkg::CLS_FU_START, rtpfua_pkg::CLS_FU_MID: has_data = 1'b1;
        default: ;
      endcase
    end

    if (eod) begin
      byte_position_next = 7'd0;
      packet_class_next  = rtpfua_pkg::CLS_IGNORED;
    end else if (byte_position < rtpfua_pkg::PosMax) begin
      byte_position_next = byte_position + 7'd1;
    end
  end

  // Pack results in fixed order: discard, data, commit
  always_comb begin
    burst.count = {1'b0, has_disc} + {1'b0, has_data} + {1'b0, has_commit};
    burst.kind[0] = has_disc ? rtpfua_pkg::KIND_DISCARD :
                    has_data ? rtpfua_pkg::KIND_DATA : rtpfua_pkg::KIND_COMMIT;
    burst.kind[1] = (has_disc && has_data) ? rtpfua_pkg::KIND_DATA : rtpfua_pkg::KIND_COMMIT;
    burst.kind[2] = rtpfua_pkg::KIND_COMMIT;
    burst.value[0] = (!has_disc && has_data) ? data_val : 8'd0;
    burst.value[1] = (has_disc && has_data) ? data_val : 8'd0;
    burst.value[2] = 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= 7'd0;
      contributor_count <= 4'd0;
      saved_indicator   <= 8'd0;
      packet_class      <= rtpfua_pkg::CLS_IGNORED;
      nal_open          <= 1'b0;
    end else if (take) begin
      byte_position     <= byte_position_next;
      contributor_count <= contributor_count_next;
      saved_indicator   <= saved_indicator_next;
      packet_class      <= packet_class_next;
      nal_open          <= nal_open_next;
    end
  end

endmodule

### sv/rtpfua_out_seq.sv
// Result register: holds the results of one byte and shifts them out in order.
// Depends on rtpfua_pkg.
module rtpfua_out_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  rtpfua_pkg::burst_t burst,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_value,
  output logic               last_of_run
);

  logic [1:0]         rem;
  rtpfua_pkg::burst_t held;
  logic               xfer;

  assign xfer        = out_valid && out_ready;
  assign out_valid   = (rem != 2'd0);
  assign can_load    = (rem == 2'd0) || (rem == 2'd1 && out_ready);
  assign out_kind    = held.kind[0];
  assign out_value   = held.value[0];
  assign last_of_run = (rem == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (load) begin
      rem <= burst.count;
    end else if (xfer) begin
      rem <= rem - 2'd1;
    end
  end

  // Advance the queue by one entry per transfer
  always_ff @(posedge clk) begin
    if (load) begin
      held <= burst;
    end else if (xfer) begin
      held.kind[0]  <= held.kind[1];
      held.kind[1]  <= held.kind[2];
      held.value[0] <= held.value[1];
      held.value[1] <= held.value[2];
    end
  end

endmodule
